>>> hdl/lip_pkg.sv
// ----------------------------------------------------------------------------
// lip_pkg: shared types, widths and helpers for the line intersection block
// Holds the derived datapath widths, the beat formats between the front and
// back parts, and the per-bit divider step used by the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lip_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_W      = 32;

	// Derived datapath widths.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DET_W  = PROD_W + 1;
	localparam int NUM_W  = DIFF_W + DET_W + 1;
	localparam int SH_W   = NUM_W + FRAC_BITS;

	// Queue sizing, shared by the middle and the result queue.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// The point (-1,-1) in fixed point.
	localparam logic [OUT_W-1:0] NEG_ONE_FIX =
		~((OUT_W'(1) << FRAC_BITS) - OUT_W'(1));
	localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_PARALLEL  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	// Beat from the front part to the back part.
	typedef struct packed {
		logic [SH_W-1:0]  nmag_x;
		logic [SH_W-1:0]  nmag_y;
		logic [DET_W-1:0] dmag;
		logic             qneg_x;
		logic             qneg_y;
		logic             par;
	} mid_t;

	// One coordinate inside the divider: partial remainder and the
	// numerator word that fills up with quotient bits from the bottom.
	typedef struct packed {
		logic [DET_W-1:0] rem;
		logic [SH_W-1:0]  nq;
	} lane_t;

	typedef struct packed {
		lane_t            x;
		lane_t            y;
		logic [DET_W-1:0] dmag;
		logic             qneg_x;
		logic             qneg_y;
		logic             par;
	} div_t;

	typedef struct packed {
		logic [OUT_W-1:0] cross_x;
		logic [OUT_W-1:0] cross_y;
		status_t          status;
	} res_t;

	// One restoring division step on one coordinate.
	function automatic lane_t lane_step(lane_t l, logic [DET_W-1:0] d);
		logic [DET_W:0] part;
		lane_t          r;
		part = {l.rem, l.nq[SH_W-1]};
		r.nq = {l.nq[SH_W-2:0], 1'b0};
		if (part >= {1'b0, d}) begin
			part = part - {1'b0, d};
			r.nq[0] = 1'b1;
		end
		r.rem = part[DET_W-1:0];
		return r;
	endfunction

	function automatic div_t div_step(div_t s);
		div_t r;
		r   = s;
		r.x = lane_step(s.x, s.dmag);
		r.y = lane_step(s.y, s.dmag);
		return r;
	endfunction

	// Saturate and sign one quotient; the top bit of the result is the
	// saturation flag.
	function automatic logic [OUT_W:0] coord_out(logic [SH_W-1:0] q, logic qneg);
		logic [OUT_W-1:0] limit;
		logic [OUT_W-1:0] mag;
		logic             sat;
		limit = qneg ? NEG_LIMIT : POS_LIMIT;
		sat   = q > SH_W'(limit);
		mag   = sat ? limit : q[OUT_W-1:0];
		return {sat, (qneg ? (~mag + OUT_W'(1)) : mag)};
	endfunction

endpackage

`default_nettype wire

>>> hdl/lip_front.sv
// ----------------------------------------------------------------------------
// lip_front: input stages of the line intersection block
// Forms the direction vectors, the determinant and two numerators, classifies
// parallel lines and writes one beat a cycle, unless held, to a small queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lip_front import lip_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic signed [COORD_BITS-1:0] a_start_x,
	input  wire logic signed [COORD_BITS-1:0] a_start_y,
	input  wire logic signed [COORD_BITS-1:0] a_end_x,
	input  wire logic signed [COORD_BITS-1:0] a_end_y,
	input  wire logic signed [COORD_BITS-1:0] b_start_x,
	input  wire logic signed [COORD_BITS-1:0] b_start_y,
	input  wire logic signed [COORD_BITS-1:0] b_end_x,
	input  wire logic signed [COORD_BITS-1:0] b_end_y,
	output logic                              mq_valid,
	output mid_t                              mq_data,
	input  wire logic                         mq_pop
);

	logic en;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [DIFF_W-1:0]     dx_s1, dy_s1, ex_s1, ey_s1, wx_s1, wy_s1;
	logic signed [DIFF_W-1:0]     dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [PROD_W-1:0]     pdet0_s2, pdet1_s2, pc0_s2, pc1_s2;
	logic signed [DET_W-1:0]      det_s3, c_s3, det_s4;
	logic signed [NUM_W-1:0]      bx_s4, dcx_s4, by_s4, dcy_s4;
	logic                         par_s4;

	logic signed [NUM_W-1:0] num_x, num_y;
	logic [SH_W-1:0]         sh_x, sh_y;
	mid_t                    mq_in;

	mid_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               mq_full;
	logic               mq_push;

	// The input stages advance unless the last one holds a beat the queue cannot take.
	assign en     = !v_s4 || !mq_full;
	assign full   = !en;
	assign accept = push && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: direction vectors and the offset between the start points.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= a_start_x;
			ay_s1 <= a_start_y;
			dx_s1 <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
			dy_s1 <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
			ex_s1 <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
			ey_s1 <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
			wx_s1 <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
			wy_s1 <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
		end
	end

	// Stage 2: cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			pdet0_s2 <= dx_s1 * ey_s1;
			pdet1_s2 <= dy_s1 * ex_s1;
			pc0_s2   <= wx_s1 * ey_s1;
			pc1_s2   <= wy_s1 * ex_s1;
		end
	end

	// Stage 3: determinant and the line parameter numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			det_s3 <= DET_W'(pdet0_s2) - DET_W'(pdet1_s2);
			c_s3   <= DET_W'(pc0_s2) - DET_W'(pc1_s2);
		end
	end

	// Stage 4: numerator products and the parallel check.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= det_s3;
			par_s4 <= (det_s3 == '0);
			bx_s4  <= ax_s3 * det_s3;
			dcx_s4 <= dx_s3 * c_s3;
			by_s4  <= ay_s3 * det_s3;
			dcy_s4 <= dy_s3 * c_s3;
		end
	end

	// Numerators scaled by the fraction bits, split into sign and magnitude.
	always_comb begin
		num_x = bx_s4 + dcx_s4;
		num_y = by_s4 + dcy_s4;
		sh_x  = SH_W'(num_x) << FRAC_BITS;
		sh_y  = SH_W'(num_y) << FRAC_BITS;
		mq_in.nmag_x = num_x[NUM_W-1] ? (~sh_x + SH_W'(1)) : sh_x;
		mq_in.nmag_y = num_y[NUM_W-1] ? (~sh_y + SH_W'(1)) : sh_y;
		mq_in.dmag   = det_s4[DET_W-1] ? (~det_s4 + DET_W'(1)) : det_s4;
		mq_in.qneg_x = num_x[NUM_W-1] ^ det_s4[DET_W-1];
		mq_in.qneg_y = num_y[NUM_W-1] ^ det_s4[DET_W-1];
		mq_in.par    = par_s4;
	end

	// Queue between the front and the back part.
	assign mq_full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign mq_push  = v_s4 && !mq_full;
	assign mq_valid = (cnt_q != '0);
	assign mq_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (mq_push) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (mq_pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(mq_push) - Q_CNT_W'(mq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (mq_push) begin
			mem_q[wptr_q] <= mq_in;
		end
	end

endmodule

`default_nettype wire

>>> hdl/lip_back.sv
// ----------------------------------------------------------------------------
// lip_back: divider pipeline and result queue of the line intersection block
// Divides both numerators by the determinant one quotient bit per stage,
// saturates, substitutes the parallel result and queues the finished beats.
// ----------------------------------------------------------------------------
`default_nettype none

module lip_back import lip_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mq_valid,
	input  wire mid_t              mq_data,
	output logic                   mq_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic signed [OUT_W-1:0] cross_x,
	output logic signed [OUT_W-1:0] cross_y,
	output logic [1:0]             status
);

	logic         en;
	logic [SH_W:0] v_q;
	div_t         stg_q [SH_W+1];

	logic [OUT_W:0] fx, fy;
	res_t           res_in;
	logic           oq_push;
	logic           oq_pop;
	logic           oq_full;
	res_t           head;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	// The divider advances unless its last stage cannot be written out.
	assign en     = !v_q[SH_W] || !oq_full;
	assign mq_pop = en && mq_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[SH_W-1:0], mq_valid};
		end
	end

	// Stage 0 loads a beat; every later stage resolves one quotient bit.
	always_ff @(posedge clk) begin
		if (en) begin
			stg_q[0].x.rem  <= '0;
			stg_q[0].x.nq   <= mq_data.nmag_x;
			stg_q[0].y.rem  <= '0;
			stg_q[0].y.nq   <= mq_data.nmag_y;
			stg_q[0].dmag   <= mq_data.dmag;
			stg_q[0].qneg_x <= mq_data.qneg_x;
			stg_q[0].qneg_y <= mq_data.qneg_y;
			stg_q[0].par    <= mq_data.par;
		end
	end

	for (genvar k = 1; k <= SH_W; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				stg_q[k] <= div_step(stg_q[k-1]);
			end
		end
	end

	// Saturation, sign and the parallel-lines substitute.
	always_comb begin
		fx = coord_out(stg_q[SH_W].x.nq, stg_q[SH_W].qneg_x);
		fy = coord_out(stg_q[SH_W].y.nq, stg_q[SH_W].qneg_y);
		if (stg_q[SH_W].par) begin
			res_in.cross_x = NEG_ONE_FIX;
			res_in.cross_y = NEG_ONE_FIX;
			res_in.status  = ST_PARALLEL;
		end else begin
			res_in.cross_x = fx[OUT_W-1:0];
			res_in.cross_y = fy[OUT_W-1:0];
			res_in.status  = (fx[OUT_W] || fy[OUT_W]) ? ST_SATURATED : ST_FOUND;
		end
	end

	// Result queue.
	assign oq_full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign oq_push = v_q[SH_W] && !oq_full;
	assign empty   = (cnt_q == '0);
	assign oq_pop  = pop && !empty;
	assign head    = mem_q[rptr_q];
	assign cross_x = head.cross_x;
	assign cross_y = head.cross_y;
	assign status  = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (oq_push) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (oq_pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(oq_push) - Q_CNT_W'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			mem_q[wptr_q] <= res_in;
		end
	end

endmodule

`default_nettype wire

>>> hdl/line_intersection_point.sv
// ----------------------------------------------------------------------------
// line_intersection_point: intersection of two lines by Cramer's rule
// Both channels look like queues. A beat carries two lines as four signed
// endpoints and is taken when push is high and full is low. Results wait
// in a four-entry queue; the oldest one is on cross_x, cross_y and status
// while empty is low and leaves when pop is high.
// Coordinates carry eight fraction bits and are truncated toward zero.
// Parallel or degenerate lines give (-1,-1) with status 1; a coordinate
// beyond 32 signed bits saturates and status reads 2.
// Throughput is one beat per cycle while the receiver keeps up. From
// accept to the pop side a beat passes four input stages, the middle
// queue, a divider of 62 stages (one stage per quotient bit of the
// 61-bit scaled numerator plus the load stage) and the result queue.
// When the receiver stalls, the result queue fills, the divider holds,
// the middle queue fills and then full rises; nothing is dropped.
// Reset clears all valid flags and both queues; no result is pending after.
// ----------------------------------------------------------------------------
`default_nettype none

module line_intersection_point import lip_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic signed [COORD_BITS-1:0] a_start_x,
	input  wire logic signed [COORD_BITS-1:0] a_start_y,
	input  wire logic signed [COORD_BITS-1:0] a_end_x,
	input  wire logic signed [COORD_BITS-1:0] a_end_y,
	input  wire logic signed [COORD_BITS-1:0] b_start_x,
	input  wire logic signed [COORD_BITS-1:0] b_start_y,
	input  wire logic signed [COORD_BITS-1:0] b_end_x,
	input  wire logic signed [COORD_BITS-1:0] b_end_y,
	output logic                              empty,
	input  wire logic                         pop,
	output logic signed [OUT_W-1:0]           cross_x,
	output logic signed [OUT_W-1:0]           cross_y,
	output logic [1:0]                        status
);

	logic mq_valid;
	logic mq_pop;
	mid_t mq_data;

	lip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.mq_valid  (mq_valid),
		.mq_data   (mq_data),
		.mq_pop    (mq_pop)
	);

	lip_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_valid (mq_valid),
		.mq_data  (mq_data),
		.mq_pop   (mq_pop),
		.empty    (empty),
		.pop      (pop),
		.cross_x  (cross_x),
		.cross_y  (cross_y),
		.status   (status)
	);

	// The back part only takes beats the middle queue actually holds.
	a_mq_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mq_pop |-> mq_valid)
		else $error("middle queue popped while empty");

	// A parallel result always carries the point (-1,-1).
	a_par_point: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_PARALLEL) |->
		(cross_x == NEG_ONE_FIX && cross_y == NEG_ONE_FIX))
		else $error("parallel result without the (-1,-1) point");

	// A saturated result has at least one coordinate at a limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_SATURATED) |->
		(cross_x == POS_LIMIT || cross_x == NEG_LIMIT ||
		 cross_y == POS_LIMIT || cross_y == NEG_LIMIT))
		else $error("saturated status without a coordinate at its limit");

endmodule

`default_nettype wire

>>> dv/line_intersection_point_test.sv
// ----------------------------------------------------------------------------
// line_intersection_point_test: self-checking bench for the line intersection
// Offers directed and random pairs of lines through the push side, predicts
// each fixed-point intersection with exact integer arithmetic and compares
// every popped beat against the oldest prediction. Both sides idle at random,
// the receiver holds off once long enough to back up the block, and the
// sender once waits until every pending result has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module line_intersection_point_test;
	import lip_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int WATCH_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 100;
	localparam int RANDOM_ITEMS = 530;
	localparam int DRAIN_AT     = 300;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax, ay, aex, aey, bx, by, bex, bey;
	} lines_t;

	typedef enum int {
		GEN_SMALL, GEN_FULL, GEN_PARALLEL, GEN_DEGENERATE, GEN_FAR
	} gen_kind_t;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic                         empty;
	logic                         pop;
	lines_t                       cur_lines;
	logic signed [OUT_W-1:0]      cross_x;
	logic signed [OUT_W-1:0]      cross_y;
	logic [1:0]                   status;

	lines_t pending_lines[$];
	res_t   expected_points[$];
	int     errors;
	int     sent;
	int     watch_cnt;
	bit     stim_done;
	bit     in_taken;
	bit     drained_once;
	int     send_gap;
	int     recv_gap;
	int     hold_cnt;
	bit     hold_done;
	int     popped;

	line_intersection_point u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.a_start_x (cur_lines.ax),
		.a_start_y (cur_lines.ay),
		.a_end_x   (cur_lines.aex),
		.a_end_y   (cur_lines.aey),
		.b_start_x (cur_lines.bx),
		.b_start_y (cur_lines.by),
		.b_end_x   (cur_lines.bex),
		.b_end_y   (cur_lines.bey),
		.empty     (empty),
		.pop       (pop),
		.cross_x   (cross_x),
		.cross_y   (cross_y),
		.status    (status)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Exact intersection: scaled numerator over the determinant, truncated.
	function automatic logic [OUT_W:0] scaled_coord(longint base, longint dir,
			longint c, longint det);
		longint num;
		longint q;
		num = (base * det + dir * c) * (longint'(1) << FRAC_BITS);
		q   = num / det;
		if (q > 64'sd2147483647) return {1'b1, POS_LIMIT};
		if (q < -64'sd2147483648) return {1'b1, NEG_LIMIT};
		return {1'b0, q[OUT_W-1:0]};
	endfunction

	function automatic res_t cross_point(lines_t l);
		longint         dx, dy, ex, ey, wx, wy, det, c;
		logic [OUT_W:0] px, py;
		res_t           r;
		dx  = longint'(l.aex) - longint'(l.ax);
		dy  = longint'(l.aey) - longint'(l.ay);
		ex  = longint'(l.bex) - longint'(l.bx);
		ey  = longint'(l.bey) - longint'(l.by);
		wx  = longint'(l.bx) - longint'(l.ax);
		wy  = longint'(l.by) - longint'(l.ay);
		det = dx * ey - dy * ex;
		c   = wx * ey - wy * ex;
		if (det == 0) begin
			r.cross_x = NEG_ONE_FIX;
			r.cross_y = NEG_ONE_FIX;
			r.status  = ST_PARALLEL;
			return r;
		end
		px = scaled_coord(longint'(l.ax), dx, c, det);
		py = scaled_coord(longint'(l.ay), dy, c, det);
		r.cross_x = px[OUT_W-1:0];
		r.cross_y = py[OUT_W-1:0];
		r.status  = (px[OUT_W] || py[OUT_W]) ? ST_SATURATED : ST_FOUND;
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rnd_coord(int lo, int hi);
		return COORD_BITS'($urandom_range(hi - lo) + lo);
	endfunction

	function automatic lines_t make_lines(gen_kind_t kind);
		lines_t l;
		int     k, dx, dy;
		l = lines_t'({$urandom, $urandom, $urandom, $urandom});
		case (kind)
			GEN_SMALL: begin
				l.ax = rnd_coord(-200, 200); l.ay = rnd_coord(-200, 200);
				l.aex = rnd_coord(-200, 200); l.aey = rnd_coord(-200, 200);
				l.bx = rnd_coord(-200, 200); l.by = rnd_coord(-200, 200);
				l.bex = rnd_coord(-200, 200); l.bey = rnd_coord(-200, 200);
			end
			GEN_PARALLEL: begin
				dx = $urandom_range(10000) - 5000;
				dy = $urandom_range(10000) - 5000;
				k  = $urandom_range(6) - 3;
				l.ax = rnd_coord(-10000, 10000); l.ay = rnd_coord(-10000, 10000);
				l.bx = rnd_coord(-10000, 10000); l.by = rnd_coord(-10000, 10000);
				l.aex = COORD_BITS'(l.ax + dx); l.aey = COORD_BITS'(l.ay + dy);
				l.bex = COORD_BITS'(l.bx + k * dx); l.bey = COORD_BITS'(l.by + k * dy);
			end
			GEN_DEGENERATE: begin
				if ($urandom_range(1)) begin
					l.aex = l.ax; l.aey = l.ay;
				end else begin
					l.bex = l.bx; l.bey = l.by;
				end
			end
			GEN_FAR: begin
				// Nearly parallel long lines mostly meet far outside the output range.
				l.ax = COORD_BITS'(-32768); l.aex = COORD_BITS'(32767);
				l.ay = rnd_coord(-100, 100); l.aey = COORD_BITS'(l.ay + 1);
				l.bx = COORD_BITS'(-32768); l.bex = COORD_BITS'(32767);
				l.by = rnd_coord(-3000, 3000);
				l.bey = COORD_BITS'(l.by + $urandom_range(2, 3));
			end
			default: ;
		endcase
		return l;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Directed lines first, then a random mix weighted toward small geometry.
	initial begin
		lines_t l;
		int     r;
		errors = 0;
		pending_lines.push_back('0);
		pending_lines.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0,
			16'sd0, 16'sd5, 16'sd10, 16'sd5});
		pending_lines.push_back({16'sd3, 16'sd0, 16'sd3, 16'sd9,
			-16'sd7, 16'sd1, -16'sd7, 16'sd2});
		pending_lines.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0,
			16'sd5, -16'sd5, 16'sd5, 16'sd5});
		pending_lines.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd1,
			16'sd1, 16'sd0, 16'sd1, 16'sd1});
		pending_lines.push_back({-16'sd1, 16'sd0, -16'sd4, 16'sd1,
			-16'sd1, -16'sd3, -16'sd2, 16'sd7});
		pending_lines.push_back({-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
			-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
		pending_lines.push_back({16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd1, 16'sd2, 16'sd3, 16'sd4});
		pending_lines.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd4,
			-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		pending_lines.push_back({16'sd0, 16'sd0, 16'sd2, 16'sd2,
			16'sd5, 16'sd5, 16'sd9, 16'sd9});
		pending_lines.push_back({-16'sd32768, 16'sd0, 16'sd32767, 16'sd1,
			-16'sd32768, 16'sd100, 16'sd32767, 16'sd102});
		pending_lines.push_back({-16'sd32768, 16'sd0, 16'sd32767, 16'sd1,
			-16'sd32768, -16'sd100, 16'sd32767, -16'sd98});
		pending_lines.push_back({16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
			16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768});
		pending_lines.push_back({-16'sd1, -16'sd1, -16'sd1, -16'sd1,
			-16'sd1, -16'sd1, -16'sd1, -16'sd1});
		for (int i = 0; i < 6; i++) pending_lines.push_back(make_lines(GEN_FAR));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 45) l = make_lines(GEN_SMALL);
			else if (r < 75) l = make_lines(GEN_FULL);
			else if (r < 87) l = make_lines(GEN_PARALLEL);
			else if (r < 93) l = make_lines(GEN_DEGENERATE);
			else l = make_lines(GEN_FAR);
			pending_lines.push_back(l);
		end
		stim_done = 1'b1;
	end

	// Reset once at the start.
	initial begin
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		push         = 1'b0;
		pop          = 1'b0;
		cur_lines    = '0;
		sent         = 0;
		send_gap     = 0;
		recv_gap     = 0;
		hold_cnt     = 0;
		hold_done    = 1'b0;
		drained_once = 1'b0;
		in_taken     = 1'b0;
		popped       = 0;
		watch_cnt    = 0;
	end

	// Input beats taken at this edge feed the expected results.
	always @(posedge clk) begin
		in_taken <= arst_n && push && !full;
		if (arst_n && push && !full)
			expected_points.push_back(cross_point(cur_lines));
	end

	// Driver: holds a beat until it is taken, then idles or offers the next.
	always @(negedge clk) begin
		if (arst_n && !(push && !in_taken)) begin
			if (in_taken) sent <= sent + 1;
			if (sent + in_taken == DRAIN_AT && !drained_once) begin
				push <= 1'b0;
				if (expected_points.size() == 0 && !in_taken) drained_once <= 1'b1;
			end else if (send_gap > 0) begin
				push     <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_lines.size() > 0) begin
				cur_lines <= pending_lines.pop_front();
				push      <= 1'b1;
				// Every other stretch of 64 beats runs without idling.
				send_gap  <= (sent / 64) % 2 ? 0 : idle_len();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: random idling plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && popped >= 100) begin
				pop <= 1'b0;
				if (hold_cnt == 400) hold_done <= 1'b1;
				else hold_cnt <= hold_cnt + 1;
			end else if (recv_gap > 0) begin
				pop      <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				pop      <= 1'b1;
				recv_gap <= (popped / 80) % 2 ? 0 : idle_len();
			end
		end
	end

	// Monitor: each popped beat against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			popped <= popped + 1;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d status=%0d",
					$time, cross_x, cross_y, status);
				errors = errors + 1;
			end else begin
				want = expected_points.pop_front();
				if (cross_x !== want.cross_x) begin
					$display("%0t: cross_x expected %0d actual %0d", $time,
						$signed(want.cross_x), cross_x);
					errors = errors + 1;
				end
				if (cross_y !== want.cross_y) begin
					$display("%0t: cross_y expected %0d actual %0d", $time,
						$signed(want.cross_y), cross_y);
					errors = errors + 1;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, status);
					errors = errors + 1;
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			watch_cnt <= 0;
		end else if (watch_cnt >= WATCH_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
			$display("line_intersection_point_test failed");
			$finish;
		end else begin
			watch_cnt <= watch_cnt + 1;
		end
	end

	// End of run: all beats sent, all results seen, then a quiet tail.
	initial begin
		wait (stim_done);
		wait (pending_lines.size() == 0 && !push);
		wait (expected_points.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("line_intersection_point_test passed");
		end else begin
			$display("%0d results left over", expected_points.size());
			$display("line_intersection_point_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hdl/lip_pkg.sv
hdl/lip_front.sv
hdl/lip_back.sv
hdl/line_intersection_point.sv
dv/line_intersection_point_test.sv
